### sv/bls_pkg.sv
// bls_pkg: types and constants shared by the line stepper modules
// no dependencies; compile first
`default_nettype none

package bls_pkg;

  // width of the coordinate fields on the channels
  localparam int unsigned FIELD_BITS = 12;

  // default width of the internal coordinate registers
  localparam int unsigned COORD_BITS_DEF = 12;

  // step selected by the func field
  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_ADVANCE = 1'b1
  } bls_func_t;

  typedef logic signed [FIELD_BITS-1:0] bls_field_t;

  // one input item
  typedef struct packed {
    bls_func_t  func;
    bls_field_t start_x;
    bls_field_t start_y;
    bls_field_t end_x;
    bls_field_t end_y;
  } bls_item_t;

  // one result item
  typedef struct packed {
    bls_field_t pixel_x;
    bls_field_t pixel_y;
    logic       pixel_valid;
  } bls_pix_t;

endpackage

`default_nettype wire

### sv/bls_ifs.sv
// bls_item_if and bls_pix_if: valid/ready channels for input and result items
// depends on bls_pkg
`default_nettype none

interface bls_item_if;
  import bls_pkg::*;

  logic      valid;
  logic      ready;
  bls_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bls_pix_if;
  import bls_pkg::*;

  logic     valid;
  logic     ready;
  bls_pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/bresenham_line_stepper_core.sv
// Line stepper core: scan converts a line one pixel per item. A load item
// sets up the line from its endpoints and returns the start pixel (pixel_valid
// low for a zero-length line); each advance item returns the next pixel, or
// pixel_valid low once the line has ended. Every item gives exactly one result.
// One item is taken per clock unless a stalled result holds back the input; an
// item passes the input register, then the step with its state update, then
// the result register, and an advance may follow a load or another advance in
// the very next cycle. A stalled result holds back the input only once both
// registers are full. The error term and current pixel are updated as each
// item is taken. COORD_BITS sets the width of the internal coordinate registers.
// top level; depends on bls_pkg, bls_ifs, bls_in_reg, bls_step, bls_out_reg
`default_nettype none

module bresenham_line_stepper_core #(
  parameter int unsigned COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bls_item_if.sink  in_item,
  bls_pix_if.source out_pix
);
  import bls_pkg::*;

  bls_item_if item_q ();
  bls_pix_if  pix_d ();

  // input register
  bls_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (in_item),
    .dn    (item_q)
  );

  // line state and step logic
  bls_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item_q),
    .pix   (pix_d)
  );

  // result register
  bls_out_reg u_out_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (pix_d),
    .dn    (out_pix)
  );

endmodule

`default_nettype wire

### sv/bls_in_reg.sv
// bls_in_reg: input register stage for line stepper items
// depends on bls_pkg and bls_item_if
`default_nettype none

module bls_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  bls_item_if.sink   up,
  bls_item_if.source dn
);
  import bls_pkg::*;

  logic      vld_r;
  logic      vld_nxt;
  bls_item_t data_r;

  // take a new item whenever the register is empty or draining
  assign up.ready = !vld_r || dn.ready;

  always_comb begin
    vld_nxt = up.ready ? up.valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      data_r <= up.data;
    end
  end

  assign dn.valid = vld_r;
  assign dn.data  = data_r;

endmodule

`default_nettype wire

### sv/bls_out_reg.sv
// bls_out_reg: result register stage for line stepper pixels
// depends on bls_pkg and bls_pix_if
`default_nettype none

module bls_out_reg (
  input  logic      clk,
  input  logic      rst_n,
  bls_pix_if.sink   up,
  bls_pix_if.source dn
);
  import bls_pkg::*;

  logic     vld_r;
  logic     vld_nxt;
  bls_pix_t data_r;

  // hold a finished item until taken, accept the next one in the same cycle
  assign up.ready = !vld_r || dn.ready;

  always_comb begin
    vld_nxt = up.ready ? up.valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      data_r <= up.data;
    end
  end

  assign dn.valid = vld_r;
  assign dn.data  = data_r;

endmodule

`default_nettype wire

### sv/bls_step.sv
// bls_step: line state registers and the load / advance logic
// depends on bls_pkg, bls_item_if and bls_pix_if
`default_nettype none

module bls_step #(
  parameter int unsigned COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bls_item_if.sink  item,
  bls_pix_if.source pix
);
  import bls_pkg::*;

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned TW = CW + 1;   // twice an absolute delta
  localparam int unsigned EW = CW + 3;   // signed error term

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   delta_t;
  typedef logic signed [EW-1:0] err_t;

  // line state
  coord_t        cur_x_r, cur_x_nxt;
  coord_t        cur_y_r, cur_y_nxt;
  coord_t        stop_x_r, stop_x_nxt;
  coord_t        stop_y_r, stop_y_nxt;
  err_t          error_term_r, error_term_nxt;
  logic [TW-1:0] twice_abs_dx_r, twice_abs_dx_nxt;
  logic [TW-1:0] twice_abs_dy_r, twice_abs_dy_nxt;
  logic          x_negative_r, x_negative_nxt;
  logic          y_negative_r, y_negative_nxt;
  logic          x_major_r, x_major_nxt;
  logic          tie_minor_r, tie_minor_nxt;
  logic          line_valid_r, line_valid_nxt;

  logic          fire;

  // load path
  coord_t        ld_sx, ld_sy, ld_ex, ld_ey;
  delta_t        ld_dx, ld_dy;
  logic [CW-1:0] ld_adx, ld_ady;
  logic          ld_x_major;
  err_t          ld_err;
  logic          ld_valid;

  // advance path
  logic          at_stop;
  logic          minor_step;
  coord_t        x_inc, y_inc;
  logic [TW-1:0] twice_major, twice_minor;
  err_t          adv_err;

  // one item per cycle, the result register decides
  assign fire       = item.valid && pix.ready;
  assign item.ready = pix.ready;
  assign pix.valid  = item.valid;

  // endpoints brought to coordinate width, deltas and major axis
  always_comb begin
    ld_sx      = coord_t'(item.data.start_x);
    ld_sy      = coord_t'(item.data.start_y);
    ld_ex      = coord_t'(item.data.end_x);
    ld_ey      = coord_t'(item.data.end_y);
    ld_dx      = delta_t'(ld_ex) - delta_t'(ld_sx);
    ld_dy      = delta_t'(ld_ey) - delta_t'(ld_sy);
    ld_adx     = ld_dx[CW] ? CW'(-ld_dx) : CW'(ld_dx);
    ld_ady     = ld_dy[CW] ? CW'(-ld_dy) : CW'(ld_dy);
    ld_x_major = ld_adx > ld_ady;
    if (ld_x_major) begin
      ld_err   = err_t'({ld_ady, 1'b0}) - err_t'(ld_adx);
      ld_valid = ld_sx != ld_ex;
    end else begin
      ld_err   = err_t'({ld_adx, 1'b0}) - err_t'(ld_ady);
      ld_valid = ld_sy != ld_ey;
    end
  end

  // one pixel step along the major axis, minor axis on the error decision
  always_comb begin
    at_stop     = x_major_r ? (cur_x_r == stop_x_r) : (cur_y_r == stop_y_r);
    minor_step  = (!error_term_r[EW-1] && (error_term_r != '0)) ||
                  ((error_term_r == '0) && tie_minor_r);
    x_inc       = x_negative_r ? coord_t'(-1) : coord_t'(1);
    y_inc       = y_negative_r ? coord_t'(-1) : coord_t'(1);
    twice_major = x_major_r ? twice_abs_dx_r : twice_abs_dy_r;
    twice_minor = x_major_r ? twice_abs_dy_r : twice_abs_dx_r;
    adv_err     = error_term_r + err_t'(twice_minor) -
                  (minor_step ? err_t'(twice_major) : err_t'(0));
  end

  // next state
  always_comb begin
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    stop_x_nxt       = stop_x_r;
    stop_y_nxt       = stop_y_r;
    error_term_nxt   = error_term_r;
    twice_abs_dx_nxt = twice_abs_dx_r;
    twice_abs_dy_nxt = twice_abs_dy_r;
    x_negative_nxt   = x_negative_r;
    y_negative_nxt   = y_negative_r;
    x_major_nxt      = x_major_r;
    tie_minor_nxt    = tie_minor_r;
    line_valid_nxt   = line_valid_r;
    if (fire) begin
      if (item.data.func == FUNC_LOAD) begin
        cur_x_nxt        = ld_sx;
        cur_y_nxt        = ld_sy;
        stop_x_nxt       = ld_ex;
        stop_y_nxt       = ld_ey;
        error_term_nxt   = ld_err;
        twice_abs_dx_nxt = {ld_adx, 1'b0};
        twice_abs_dy_nxt = {ld_ady, 1'b0};
        x_negative_nxt   = ld_dx[CW];
        y_negative_nxt   = ld_dy[CW];
        x_major_nxt      = ld_x_major;
        tie_minor_nxt    = ld_x_major ? !ld_dx[CW] : !ld_dy[CW];
        line_valid_nxt   = ld_valid;
      end else if (line_valid_r) begin
        if (at_stop) begin
          line_valid_nxt = 1'b0;
        end else begin
          error_term_nxt = adv_err;
          if (x_major_r || minor_step) begin
            cur_x_nxt = cur_x_r + x_inc;
          end
          if (!x_major_r || minor_step) begin
            cur_y_nxt = cur_y_r + y_inc;
          end
        end
      end
    end
  end

  // result of this item, pixel zero once the line is done
  // coordinate bits go out as they are, zero filled up to the field width
  always_comb begin
    pix.data.pixel_valid = line_valid_nxt;
    pix.data.pixel_x     = line_valid_nxt ? bls_field_t'($unsigned(cur_x_nxt)) :
                                            bls_field_t'(0);
    pix.data.pixel_y     = line_valid_nxt ? bls_field_t'($unsigned(cur_y_nxt)) :
                                            bls_field_t'(0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r        <= '0;
      cur_y_r        <= '0;
      stop_x_r       <= '0;
      stop_y_r       <= '0;
      error_term_r   <= '0;
      twice_abs_dx_r <= '0;
      twice_abs_dy_r <= '0;
      x_negative_r   <= 1'b0;
      y_negative_r   <= 1'b0;
      x_major_r      <= 1'b0;
      tie_minor_r    <= 1'b0;
      line_valid_r   <= 1'b0;
    end else begin
      cur_x_r        <= cur_x_nxt;
      cur_y_r        <= cur_y_nxt;
      stop_x_r       <= stop_x_nxt;
      stop_y_r       <= stop_y_nxt;
      error_term_r   <= error_term_nxt;
      twice_abs_dx_r <= twice_abs_dx_nxt;
      twice_abs_dy_r <= twice_abs_dy_nxt;
      x_negative_r   <= x_negative_nxt;
      y_negative_r   <= y_negative_nxt;
      x_major_r      <= x_major_nxt;
      tie_minor_r    <= tie_minor_nxt;
      line_valid_r   <= line_valid_nxt;
    end
  end

  // an advance on a finished line leaves the pixel where it is
  a_idle_advance_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.data.func == FUNC_ADVANCE) && !line_valid_r |=>
      $stable(cur_x_r) && $stable(cur_y_r) && !line_valid_r)
    else $error("advance without a line moved the pixel");

  // a load makes the start the current pixel
  a_load_sets_start: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.data.func == FUNC_LOAD) |=>
      (cur_x_r == $past(ld_sx)) && (cur_y_r == $past(ld_sy)))
    else $error("load did not set the start pixel");

  // an advance short of the stop always moves along the major axis
  a_major_moves: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.data.func == FUNC_ADVANCE) && line_valid_r && !at_stop |=>
      line_valid_r &&
      (x_major_r ? (cur_x_r != $past(cur_x_r)) : (cur_y_r != $past(cur_y_r))))
    else $error("advance did not step the major axis");

endmodule

`default_nettype wire
